// ===== hw/rtl/tlq_pkg.sv =====
package tlq_pkg;

    localparam int VERTICES_DEF       = 4096;
    localparam int EULER_LEN_DEF      = 8192;
    localparam int SPARSE_LEVELS_DEF  = 13;
    localparam int MAX_DEPTH_DEF      = 256;
    localparam int MAX_SEPARATORS_DEF = 64;

    localparam int NODE_W   = 12;
    localparam int EULER_W  = 13;
    localparam int HEIGHT_W = 9;
    localparam int DEPTH_W  = 8;
    localparam int COUNT_W  = 7;
    localparam int DIST_W   = 30;
    localparam int ROW_W    = 12;
    localparam int COL_W    = 13;

    localparam logic [DIST_W-1:0] INF_DIST = 30'd999999999;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [2:0] SEL_NODE   = 3'd0;
    localparam logic [2:0] SEL_EULER  = 3'd1;
    localparam logic [2:0] SEL_HEIGHT = 3'd2;
    localparam logic [2:0] SEL_SPARSE = 3'd3;
    localparam logic [2:0] SEL_OWN    = 3'd4;
    localparam logic [2:0] SEL_DIST   = 3'd5;
    localparam logic [2:0] SEL_SEP    = 3'd6;
    localparam logic [2:0] SEL_COUNT  = 3'd7;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NODE_B,
        S_EUL_A,
        S_EUL_B,
        S_ORDER,
        S_SPARSE_L,
        S_SPARSE_R,
        S_HGT_L,
        S_HGT_R,
        S_LCA,
        S_OWN,
        S_DIRECT,
        S_COUNT,
        S_SEP,
        S_DIST_X,
        S_DIST_Y
    } state_t;

endpackage

// ===== hw/rtl/tlq_ram.sv =====
module tlq_ram #(
    parameter int    WIDTH = 8,
    parameter longint DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hw/rtl/tree_label_distance_query_unit.sv =====
// channel  direction  handshake          payload
// s_*      in         s_tvalid/s_tready  table write or distance query
// m_*      out        m_tvalid/m_tready  distance result, one per query
// a single sequencer makes at most one table read a cycle: node, euler, sparse,
// height reads to the lca; then owner depth and distance reads on the ancestor
// path, else separator count and per slot a separator and two distance reads (up
// to MAX_SEPARATORS); equal vertices skip these. s_tready is high only while idle;
// a result waits in the output register; a further query stalls at its end until
// that slot is free; rst_n clears control only; tables hold no reset value
module tree_label_distance_query_unit
    import tlq_pkg::*;
#(
    parameter int VERTICES       = VERTICES_DEF,
    parameter int EULER_LEN      = EULER_LEN_DEF,
    parameter int SPARSE_LEVELS  = SPARSE_LEVELS_DEF,
    parameter int MAX_DEPTH      = MAX_DEPTH_DEF,
    parameter int MAX_SEPARATORS = MAX_SEPARATORS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // row_index, column_index, write_value, vertex_a, vertex_b
    input  logic [79:0] s_tdata,
    // opcode, table_select
    input  logic [3:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // distance
    output logic [31:0] m_tdata,
    // no_path
    output logic [0:0]  m_tuser
);

    localparam longint SP_DEPTH   = longint'(SPARSE_LEVELS) * EULER_LEN;
    localparam longint DIST_DEPTH = longint'(VERTICES) * MAX_DEPTH;
    localparam longint SEP_DEPTH  = longint'(VERTICES) * MAX_SEPARATORS;
    localparam int VW  = $clog2(VERTICES);
    localparam int SAW = $clog2(SP_DEPTH);
    localparam int DAW = $clog2(DIST_DEPTH);
    localparam int SPW = $clog2(SEP_DEPTH);
    localparam int KW  = $clog2(SPARSE_LEVELS);
    localparam int CW  = $clog2(MAX_SEPARATORS + 1);

    state_t state_reg, state_next;

    logic              opcode;
    logic [2:0]        table_select;
    logic [ROW_W-1:0]  row_index;
    logic [COL_W-1:0]  column_index;
    logic [DIST_W-1:0] write_value;
    logic [NODE_W-1:0] vertex_a, vertex_b;
    logic              accept, wr;
    logic              row_ok;

    logic [NODE_W-1:0]   x_reg, y_reg, left_reg, right_reg, lca_reg, vb_reg;
    logic [EULER_W-1:0]  p_reg, lo_reg, hi_reg, q2_reg;
    logic [KW-1:0]       k_reg;
    logic [HEIGHT_W-1:0] hl_reg;
    logic [DEPTH_W-1:0]  dep_reg;
    logic [DIST_W-1:0]   dx_reg, best_reg;
    logic [CW-1:0]       n_reg, i_reg;
    logic                rd_zero_reg, rd_inf_reg;
    logic                rd_zero, rd_inf;
    logic                m_tvalid_reg;
    logic [DIST_W-1:0]   m_dist_reg;
    logic                m_nopath_reg;
    logic                direct_pending_reg;

    logic [VW-1:0]       node_raddr, eul_raddr, hgt_raddr, own_raddr, cnt_raddr;
    logic [SAW-1:0]      sp_raddr;
    logic [DAW-1:0]      dist_raddr;
    logic [SPW-1:0]      sep_raddr;
    logic [NODE_W-1:0]   node_rdata, sp_rdata;
    logic [EULER_W-1:0]  eul_rdata;
    logic [HEIGHT_W-1:0] hgt_rdata;
    logic [DEPTH_W-1:0]  own_rdata, sep_rdata;
    logic [COUNT_W-1:0]  cnt_rdata;
    logic [DIST_W-1:0]   dist_rdata;

    logic [NODE_W-1:0]   node_eff, sp_eff;
    logic [EULER_W-1:0]  eul_eff;
    logic [HEIGHT_W-1:0] hgt_eff;
    logic [DEPTH_W-1:0]  own_eff, sep_eff;
    logic [COUNT_W-1:0]  cnt_eff;
    logic [DIST_W-1:0]   dist_eff;

    logic [EULER_W-1:0]  diff_c, q2_c;
    logic [KW-1:0]       k_c;
    logic [NODE_W-1:0]   lca_c, anc_x, anc_y;
    logic                anc_c, swap_c, done_free;
    logic [DIST_W:0]     sum_c;
    logic [CW:0]         i_inc;
    logic [CW-1:0]       n_c;
    logic [DIST_W-1:0]   direct_c, result_c;

    function automatic logic vok(input logic [NODE_W-1:0] v);
        return 32'(v) < VERTICES;
    endfunction

    function automatic logic [SAW-1:0] sp_addr(input logic [KW-1:0] k,
                                                input logic [EULER_W-1:0] at);
        return SAW'(64'(k) * EULER_LEN + 64'(at));
    endfunction

    function automatic logic [DAW-1:0] dist_addr(input logic [NODE_W-1:0] n,
                                                  input logic [DEPTH_W-1:0] d);
        return DAW'(64'(n) * MAX_DEPTH + 64'(d));
    endfunction

    function automatic logic [SPW-1:0] sep_addr(input logic [NODE_W-1:0] n,
                                                 input logic [CW:0] i);
        return SPW'(64'(n) * MAX_SEPARATORS + 64'(i));
    endfunction

    function automatic logic dep_ok(input logic [DEPTH_W-1:0] d);
        return 32'(d) < MAX_DEPTH;
    endfunction

    assign opcode       = s_tuser[0];
    assign table_select = s_tuser[3:1];
    assign row_index    = s_tdata[11:0];
    assign column_index = s_tdata[24:12];
    assign write_value  = s_tdata[54:25];
    assign vertex_a     = s_tdata[66:55];
    assign vertex_b     = s_tdata[78:67];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign wr       = accept && (opcode == OP_WRITE);
    assign row_ok   = 32'(row_index) < VERTICES;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, m_dist_reg};
    assign m_tuser  = m_nopath_reg;

    // table stores
    tlq_ram #(.WIDTH(NODE_W), .DEPTH(VERTICES)) u_node (
        .clk(clk), .wr_en(wr && table_select == SEL_NODE && row_ok),
        .wr_addr(VW'(row_index)), .wr_data(write_value[NODE_W-1:0]),
        .rd_addr(node_raddr), .rd_data(node_rdata));

    tlq_ram #(.WIDTH(EULER_W), .DEPTH(VERTICES)) u_euler (
        .clk(clk), .wr_en(wr && table_select == SEL_EULER && row_ok),
        .wr_addr(VW'(row_index)), .wr_data(write_value[EULER_W-1:0]),
        .rd_addr(eul_raddr), .rd_data(eul_rdata));

    tlq_ram #(.WIDTH(HEIGHT_W), .DEPTH(VERTICES)) u_height (
        .clk(clk), .wr_en(wr && table_select == SEL_HEIGHT && row_ok),
        .wr_addr(VW'(row_index)), .wr_data(write_value[HEIGHT_W-1:0]),
        .rd_addr(hgt_raddr), .rd_data(hgt_rdata));

    tlq_ram #(.WIDTH(NODE_W), .DEPTH(SP_DEPTH)) u_sparse (
        .clk(clk),
        .wr_en(wr && table_select == SEL_SPARSE && 32'(row_index) < SPARSE_LEVELS
               && 32'(column_index) < EULER_LEN),
        .wr_addr(SAW'(64'(row_index) * EULER_LEN + 64'(column_index))),
        .wr_data(write_value[NODE_W-1:0]),
        .rd_addr(sp_raddr), .rd_data(sp_rdata));

    tlq_ram #(.WIDTH(DEPTH_W), .DEPTH(VERTICES)) u_own (
        .clk(clk), .wr_en(wr && table_select == SEL_OWN && row_ok),
        .wr_addr(VW'(row_index)), .wr_data(write_value[DEPTH_W-1:0]),
        .rd_addr(own_raddr), .rd_data(own_rdata));

    tlq_ram #(.WIDTH(DIST_W), .DEPTH(DIST_DEPTH)) u_dist (
        .clk(clk),
        .wr_en(wr && table_select == SEL_DIST && row_ok
               && 32'(column_index) < MAX_DEPTH),
        .wr_addr(DAW'(64'(row_index) * MAX_DEPTH + 64'(column_index))),
        .wr_data(write_value),
        .rd_addr(dist_raddr), .rd_data(dist_rdata));

    tlq_ram #(.WIDTH(DEPTH_W), .DEPTH(SEP_DEPTH)) u_sep (
        .clk(clk),
        .wr_en(wr && table_select == SEL_SEP && row_ok
               && 32'(column_index) < MAX_SEPARATORS),
        .wr_addr(SPW'(64'(row_index) * MAX_SEPARATORS + 64'(column_index))),
        .wr_data(write_value[DEPTH_W-1:0]),
        .rd_addr(sep_raddr), .rd_data(sep_rdata));

    tlq_ram #(.WIDTH(COUNT_W), .DEPTH(VERTICES)) u_count (
        .clk(clk), .wr_en(wr && table_select == SEL_COUNT && row_ok),
        .wr_addr(VW'(row_index)), .wr_data(write_value[COUNT_W-1:0]),
        .rd_addr(cnt_raddr), .rd_data(cnt_rdata));

    // out-of-range reads give zero, or infinity for distances
    assign node_eff = rd_zero_reg ? '0 : node_rdata;
    assign eul_eff  = rd_zero_reg ? '0 : eul_rdata;
    assign hgt_eff  = rd_zero_reg ? '0 : hgt_rdata;
    assign sp_eff   = rd_zero_reg ? '0 : sp_rdata;
    assign own_eff  = rd_zero_reg ? '0 : own_rdata;
    assign sep_eff  = rd_zero_reg ? '0 : sep_rdata;
    assign cnt_eff  = rd_zero_reg ? '0 : cnt_rdata;
    assign dist_eff = rd_inf_reg ? INF_DIST : dist_rdata;

    // sparse level from the range length
    always_comb
    begin
        logic [KW:0] kk;
        kk = '0;
        diff_c = hi_reg - lo_reg;
        for (int b = 1; b < EULER_W; b++)
        begin
            if (diff_c[b])
            begin
                kk = (KW+1)'(b);
            end
        end
        if (32'(kk) > SPARSE_LEVELS - 1)
        begin
            k_c = KW'(SPARSE_LEVELS - 1);
        end
        else
        begin
            k_c = KW'(kk);
        end
        q2_c = hi_reg - EULER_W'(14'd1 << k_c) + EULER_W'(1);
    end

    assign lca_c  = (hl_reg < hgt_eff) ? left_reg : right_reg;
    assign anc_c  = (lca_c == x_reg) || (lca_c == y_reg);
    assign swap_c = (lca_c == y_reg);
    assign anc_x  = swap_c ? y_reg : x_reg;
    assign anc_y  = swap_c ? x_reg : y_reg;
    assign sum_c  = {1'b0, dx_reg} + {1'b0, dist_eff};
    assign i_inc  = {1'b0, i_reg} + (CW+1)'(1);
    assign n_c    = (32'(cnt_eff) > MAX_SEPARATORS) ? CW'(MAX_SEPARATORS) : CW'(cnt_eff);
    assign done_free = !m_tvalid_reg || m_tready;

    // direct path: saturate the single distance read
    assign direct_c = (dist_eff > INF_DIST) ? INF_DIST : dist_eff;
    assign result_c = direct_pending_reg ? direct_c : best_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && opcode == OP_QUERY)
                begin
                    state_next = (vertex_a == vertex_b) ? S_DIRECT : S_NODE_B;
                end
            end
            S_NODE_B:   state_next = S_EUL_A;
            S_EUL_A:    state_next = S_EUL_B;
            S_EUL_B:    state_next = S_ORDER;
            S_ORDER:    state_next = S_SPARSE_L;
            S_SPARSE_L: state_next = S_SPARSE_R;
            S_SPARSE_R: state_next = S_HGT_L;
            S_HGT_L:    state_next = S_HGT_R;
            S_HGT_R:    state_next = S_LCA;
            S_LCA:      state_next = anc_c ? S_OWN : S_COUNT;
            S_OWN:      state_next = S_DIRECT;
            S_DIRECT:
            begin
                if (done_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_COUNT:    state_next = (n_c == '0) ? S_DIRECT : S_SEP;
            S_SEP:      state_next = S_DIST_X;
            S_DIST_X:   state_next = S_DIST_Y;
            S_DIST_Y:   state_next = (i_inc < {1'b0, n_reg}) ? S_SEP : S_DIRECT;
            default:    state_next = S_IDLE;
        endcase
    end

    // read addresses
    always_comb
    begin
        node_raddr = '0;
        eul_raddr  = '0;
        hgt_raddr  = '0;
        own_raddr  = '0;
        cnt_raddr  = '0;
        sp_raddr   = '0;
        dist_raddr = '0;
        sep_raddr  = '0;
        rd_zero    = 1'b0;
        rd_inf     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                node_raddr = VW'(vertex_a);
                rd_zero    = !vok(vertex_a);
            end
            S_NODE_B:
            begin
                node_raddr = VW'(vb_reg);
                rd_zero    = !vok(vb_reg);
            end
            S_EUL_A:
            begin
                eul_raddr = VW'(x_reg);
                rd_zero   = !vok(x_reg);
            end
            S_EUL_B:
            begin
                eul_raddr = VW'(y_reg);
                rd_zero   = !vok(y_reg);
            end
            S_SPARSE_L:
            begin
                sp_raddr = sp_addr(k_c, lo_reg);
                rd_zero  = !(32'(lo_reg) < EULER_LEN);
            end
            S_SPARSE_R:
            begin
                sp_raddr = sp_addr(k_reg, q2_reg);
                rd_zero  = !(32'(q2_reg) < EULER_LEN);
            end
            S_HGT_L:
            begin
                hgt_raddr = VW'(left_reg);
                rd_zero   = !vok(left_reg);
            end
            S_HGT_R:
            begin
                hgt_raddr = VW'(right_reg);
                rd_zero   = !vok(right_reg);
            end
            S_LCA:
            begin
                if (anc_c)
                begin
                    own_raddr = VW'(anc_x);
                    rd_zero   = !vok(anc_x);
                end
                else
                begin
                    cnt_raddr = VW'(lca_c);
                    rd_zero   = !vok(lca_c);
                end
            end
            S_OWN:
            begin
                dist_raddr = dist_addr(y_reg, own_eff);
                rd_inf     = !vok(y_reg) || !dep_ok(own_eff);
            end
            S_COUNT:
            begin
                sep_raddr = sep_addr(lca_reg, '0);
                rd_zero   = !vok(lca_reg);
            end
            S_SEP:
            begin
                dist_raddr = dist_addr(x_reg, sep_eff);
                rd_inf     = !vok(x_reg) || !dep_ok(sep_eff);
            end
            S_DIST_X:
            begin
                dist_raddr = dist_addr(y_reg, dep_reg);
                rd_inf     = !vok(y_reg) || !dep_ok(dep_reg);
            end
            S_DIST_Y:
            begin
                sep_raddr = sep_addr(lca_reg, i_inc);
                rd_zero   = !vok(lca_reg);
            end
            default:
            begin
                rd_zero = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DIRECT && done_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_zero_reg <= rd_zero;
        rd_inf_reg  <= rd_inf;
        case (state_reg)
            S_IDLE:
            begin
                best_reg <= '0;
                vb_reg   <= vertex_b;
            end
            S_NODE_B:   x_reg <= node_eff;
            S_EUL_A:    y_reg <= node_eff;
            S_EUL_B:    p_reg <= eul_eff;
            S_ORDER:
            begin
                lo_reg <= (p_reg > eul_eff) ? eul_eff : p_reg;
                hi_reg <= (p_reg > eul_eff) ? p_reg : eul_eff;
            end
            S_SPARSE_L:
            begin
                k_reg  <= k_c;
                q2_reg <= q2_c;
            end
            S_SPARSE_R: left_reg  <= sp_eff;
            S_HGT_L:    right_reg <= sp_eff;
            S_HGT_R:    hl_reg    <= hgt_eff;
            S_LCA:
            begin
                lca_reg <= lca_c;
                if (anc_c)
                begin
                    x_reg <= anc_x;
                    y_reg <= anc_y;
                end
            end
            S_OWN:
            begin
                best_reg <= '0;
            end
            S_DIRECT:
            begin
                best_reg <= result_c;
                if (done_free)
                begin
                    m_dist_reg   <= result_c;
                    m_nopath_reg <= (result_c == INF_DIST);
                end
            end
            S_COUNT:
            begin
                n_reg    <= n_c;
                i_reg    <= '0;
                best_reg <= INF_DIST;
            end
            S_SEP:      dep_reg <= sep_eff;
            S_DIST_X:   dx_reg  <= dist_eff;
            S_DIST_Y:
            begin
                if (sum_c < {1'b0, best_reg})
                begin
                    best_reg <= sum_c[DIST_W-1:0];
                end
                i_reg <= i_inc[CW-1:0];
            end
            default:
            begin
                dep_reg <= dep_reg;
            end
        endcase
    end

    // the direct path result is taken on the cycle after the read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direct_pending_reg <= 1'b0;
        end
        else
        begin
            direct_pending_reg <= (state_reg == S_OWN);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> state_reg == S_IDLE)
        else $error("request taken outside idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SEP |-> i_reg < n_reg)
        else $error("separator slot past count");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIST_Y |-> best_reg <= INF_DIST)
        else $error("running minimum above infinity");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import tlq_pkg::*;

    localparam int HOLD_LIMIT = 4000;
    localparam int RANDOM_ITEMS = 1250;
    localparam int QUIET_FROM = 1100;

    typedef struct {
        logic                op;
        logic [2:0]          sel;
        logic [ROW_W-1:0]    row;
        logic [COL_W-1:0]    col;
        logic [DIST_W-1:0]   val;
        logic [NODE_W-1:0]   va;
        logic [NODE_W-1:0]   vb;
        bit                  typed;
        logic [DIST_W-1:0]   want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic [3:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;

    // shadow copy of the index tables, only written entries exist
    int unsigned node_map[int];
    int unsigned euler_pos[int];
    int unsigned height_of[int];
    int unsigned sparse_min[int];
    int unsigned depth_of[int];
    int unsigned anc_dist[int];
    int unsigned sep_depth[int];
    int unsigned sep_cnt[int];

    logic [DIST_W-1:0] dist_q[$];
    int unsigned node_pool[12];
    int unsigned vertex_pool[20];
    int unsigned euler_pool[12];

    bit quiet;
    int errors;
    int items;
    int n_queries;
    int n_writes;
    int n_results;
    int hold_cnt;
    int stall_left;

    tree_label_distance_query_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int unsigned field_mask(input logic [2:0] sel);
        case (sel)
            SEL_NODE, SEL_SPARSE: return (1 << NODE_W) - 1;
            SEL_EULER:            return (1 << EULER_W) - 1;
            SEL_HEIGHT:           return (1 << HEIGHT_W) - 1;
            SEL_OWN, SEL_SEP:     return (1 << DEPTH_W) - 1;
            SEL_COUNT:            return (1 << COUNT_W) - 1;
            default:              return (1 << DIST_W) - 1;
        endcase
    endfunction

    // apply one table write, out-of-range addresses are dropped
    function automatic void store_word(input logic [2:0] sel, input int row, input int col,
                                       input logic [DIST_W-1:0] val);
        int unsigned v;
        v = val & field_mask(sel);
        case (sel)
            SEL_NODE:   node_map[row] = v;
            SEL_EULER:  euler_pos[row] = v;
            SEL_HEIGHT: height_of[row] = v;
            SEL_SPARSE: if (row < SPARSE_LEVELS_DEF) sparse_min[row * EULER_LEN_DEF + col] = v;
            SEL_OWN:    depth_of[row] = v;
            SEL_DIST:   if (col < MAX_DEPTH_DEF) anc_dist[row * MAX_DEPTH_DEF + col] = v;
            SEL_SEP:    if (col < MAX_SEPARATORS_DEF) sep_depth[row * MAX_SEPARATORS_DEF + col] = v;
            default:    sep_cnt[row] = v;
        endcase
    endfunction

    // distance for a query; returns 1, or 0 and the first unwritten address it would read
    function automatic bit query_distance(input int a, input int b, output logic [DIST_W-1:0] res,
                                          output logic [2:0] msel, output int mrow,
                                          output int mcol);
        int unsigned x, y, p, q, t, len, v, k, q2, left, right, lca, n, dd;
        longint unsigned best, s;
        res = '0;
        msel = SEL_NODE;
        mrow = 0;
        mcol = 0;
        if (a == b)
            return 1;
        if (!node_map.exists(a)) begin mrow = a; return 0; end
        if (!node_map.exists(b)) begin mrow = b; return 0; end
        x = node_map[a];
        y = node_map[b];
        msel = SEL_EULER;
        if (!euler_pos.exists(x)) begin mrow = x; return 0; end
        if (!euler_pos.exists(y)) begin mrow = y; return 0; end
        p = euler_pos[x];
        q = euler_pos[y];
        if (p > q) begin t = p; p = q; q = t; end
        len = q - p + 1;
        k = 0;
        if (len > 2)
        begin
            v = len - 1;
            while (v > 1) begin v = v >> 1; k++; end
        end
        if (k > SPARSE_LEVELS_DEF - 1)
            k = SPARSE_LEVELS_DEF - 1;
        q2 = q - (1 << k) + 1;
        msel = SEL_SPARSE;
        mrow = k;
        if (!sparse_min.exists(k * EULER_LEN_DEF + p)) begin mcol = p; return 0; end
        if (!sparse_min.exists(k * EULER_LEN_DEF + q2)) begin mcol = q2; return 0; end
        left = sparse_min[k * EULER_LEN_DEF + p];
        right = sparse_min[k * EULER_LEN_DEF + q2];
        msel = SEL_HEIGHT;
        mcol = 0;
        if (!height_of.exists(left)) begin mrow = left; return 0; end
        if (!height_of.exists(right)) begin mrow = right; return 0; end
        lca = (height_of[left] < height_of[right]) ? left : right;
        if (lca == x || lca == y)
        begin
            if (lca == y) begin t = x; x = y; y = t; end
            msel = SEL_OWN;
            if (!depth_of.exists(x)) begin mrow = x; return 0; end
            msel = SEL_DIST;
            if (!anc_dist.exists(y * MAX_DEPTH_DEF + depth_of[x]))
            begin
                mrow = y;
                mcol = depth_of[x];
                return 0;
            end
            dd = anc_dist[y * MAX_DEPTH_DEF + depth_of[x]];
            res = (dd > INF_DIST) ? INF_DIST : dd;
            return 1;
        end
        msel = SEL_COUNT;
        if (!sep_cnt.exists(lca)) begin mrow = lca; return 0; end
        n = (sep_cnt[lca] > MAX_SEPARATORS_DEF) ? MAX_SEPARATORS_DEF : sep_cnt[lca];
        best = INF_DIST;
        for (int i = 0; i < n; i++)
        begin
            msel = SEL_SEP;
            if (!sep_depth.exists(lca * MAX_SEPARATORS_DEF + i)) begin mrow = lca; mcol = i; return 0; end
            dd = sep_depth[lca * MAX_SEPARATORS_DEF + i];
            msel = SEL_DIST;
            mcol = dd;
            if (!anc_dist.exists(x * MAX_DEPTH_DEF + dd)) begin mrow = x; return 0; end
            if (!anc_dist.exists(y * MAX_DEPTH_DEF + dd)) begin mrow = y; return 0; end
            s = longint'(anc_dist[x * MAX_DEPTH_DEF + dd]) + anc_dist[y * MAX_DEPTH_DEF + dd];
            if (s < best)
                best = s;
        end
        res = best[DIST_W-1:0];
        return 1;
    endfunction

    // word for a table, upper bits beyond the entry width are random
    function automatic logic [DIST_W-1:0] pick_word(input logic [2:0] sel, input int a, input int b);
        int unsigned v;
        int unsigned r;
        r = $urandom_range(0, 2);
        case (sel)
            SEL_NODE:   v = node_pool[$urandom_range(0, 11)];
            SEL_EULER:  v = euler_pool[$urandom_range(0, 11)];
            SEL_HEIGHT: v = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom;
            SEL_SPARSE:
                if (r == 0 && node_map.exists(a))
                    v = node_map[a];
                else if (r == 1 && node_map.exists(b))
                    v = node_map[b];
                else
                    v = node_pool[$urandom_range(0, 11)];
            SEL_DIST:   v = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 1000000);
            SEL_COUNT:  v = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 127) : $urandom_range(0, 6);
            default:    v = $urandom;
        endcase
        return ((v & field_mask(sel)) | ($urandom & ~field_mask(sel))) & 30'h3FFFFFFF;
    endfunction

    task automatic send(input logic op, input logic [2:0] sel, input int row, input int col,
                        input logic [DIST_W-1:0] val, input int va, input int vb,
                        input bit typed, input logic [DIST_W-1:0] want, input bit counted);
        logic [DIST_W-1:0] res;
        logic [2:0] msel;
        int mrow;
        int mcol;
        if (op == OP_QUERY)
        begin
            sel = $urandom;
            row = $urandom;
            col = $urandom;
            val = $urandom;
        end
        else
        begin
            va = $urandom;
            vb = $urandom;
        end
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= {sel, op};
        s_tdata <= {1'b0, vb[NODE_W-1:0], va[NODE_W-1:0], val, col[COL_W-1:0], row[ROW_W-1:0]};
        do
            @(posedge clk);
        while (!s_tready);
        if (op == OP_WRITE)
        begin
            store_word(sel, row[ROW_W-1:0], col[COL_W-1:0], val);
            n_writes++;
        end
        else
        begin
            void'(query_distance(va[NODE_W-1:0], vb[NODE_W-1:0], res, msel, mrow, mcol));
            dist_q = {dist_q, (typed ? want : res)};
            n_queries++;
        end
        if (counted)
            items++;
    endtask

    // result check
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            n_results++;
            if (dist_q.size() == 0)
            begin
                $error("unexpected result distance=%0d", m_tdata[DIST_W-1:0]);
                errors++;
            end
            else
            begin
                if (m_tdata[DIST_W-1:0] !== dist_q[0])
                begin
                    $error("distance: expected %0d, got %0d", dist_q[0], m_tdata[DIST_W-1:0]);
                    errors++;
                end
                if (m_tuser[0] !== (dist_q[0] == INF_DIST))
                begin
                    $error("no_path: expected %0b, got %0b", dist_q[0] == INF_DIST, m_tuser[0]);
                    errors++;
                end
                void'(dist_q.pop_front());
            end
        end
    end

    // receiver stalls
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 4) == 0)
        begin
            stall_left <= $urandom_range(0, 2);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            hold_cnt <= 0;
        else
            hold_cnt <= hold_cnt + 1;
        if (hold_cnt >= HOLD_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        stim_row_t steps[25];
        logic [DIST_W-1:0] res;
        logic [2:0] msel;
        int mrow;
        int mcol;
        int a;
        int b;
        int r;
        logic [2:0] sel;

        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        quiet = 1'b0;
        errors = 0;
        items = 0;
        n_queries = 0;
        n_writes = 0;
        n_results = 0;
        hold_cnt = 0;
        stall_left = 0;

        node_pool[0] = 0;
        node_pool[1] = 4095;
        vertex_pool[0] = 0;
        vertex_pool[1] = 4095;
        euler_pool[0] = 0;
        euler_pool[1] = 8191;
        for (int i = 2; i < 12; i++)
        begin
            node_pool[i] = $urandom_range(0, 4095);
            euler_pool[i] = (i < 7) ? $urandom_range(0, 15) : $urandom_range(0, 8191);
        end
        for (int i = 2; i < 20; i++)
            vertex_pool[i] = $urandom_range(0, 4095);

        // equal vertices, dropped writes, ancestor path with saturation,
        // separator path with a height tie and no separators
        steps[0]  = '{OP_QUERY, SEL_NODE, 0, 0, 0, 0, 0, 1, 0};
        steps[1]  = '{OP_QUERY, SEL_NODE, 0, 0, 0, 4095, 4095, 1, 0};
        steps[2]  = '{OP_WRITE, SEL_SPARSE, 13, 0, 5, 0, 0, 0, 0};
        steps[3]  = '{OP_WRITE, SEL_SPARSE, 4095, 8191, 1, 0, 0, 0, 0};
        steps[4]  = '{OP_WRITE, SEL_DIST, 0, 256, 1, 0, 0, 0, 0};
        steps[5]  = '{OP_WRITE, SEL_SEP, 0, 64, 1, 0, 0, 0, 0};
        steps[6]  = '{OP_WRITE, SEL_NODE, 1, 0, 5, 0, 0, 0, 0};
        steps[7]  = '{OP_WRITE, SEL_NODE, 2, 0, 7, 0, 0, 0, 0};
        steps[8]  = '{OP_WRITE, SEL_EULER, 5, 0, 3, 0, 0, 0, 0};
        steps[9]  = '{OP_WRITE, SEL_EULER, 7, 0, 3, 0, 0, 0, 0};
        steps[10] = '{OP_WRITE, SEL_SPARSE, 0, 3, 5, 0, 0, 0, 0};
        steps[11] = '{OP_WRITE, SEL_HEIGHT, 5, 0, 511, 0, 0, 0, 0};
        steps[12] = '{OP_WRITE, SEL_OWN, 5, 0, 200, 0, 0, 0, 0};
        steps[13] = '{OP_WRITE, SEL_DIST, 7, 200, 30'h3FFFFFFF, 0, 0, 0, 0};
        steps[14] = '{OP_QUERY, SEL_NODE, 0, 0, 0, 1, 2, 1, INF_DIST};
        steps[15] = '{OP_WRITE, SEL_DIST, 7, 200, 12345, 0, 0, 0, 0};
        steps[16] = '{OP_QUERY, SEL_NODE, 0, 0, 0, 2, 1, 1, 12345};
        steps[17] = '{OP_WRITE, SEL_NODE, 4095, 0, 9, 0, 0, 0, 0};
        steps[18] = '{OP_WRITE, SEL_EULER, 9, 0, 8191, 0, 0, 0, 0};
        steps[19] = '{OP_WRITE, SEL_SPARSE, 12, 3, 20, 0, 0, 0, 0};
        steps[20] = '{OP_WRITE, SEL_SPARSE, 12, 4096, 21, 0, 0, 0, 0};
        steps[21] = '{OP_WRITE, SEL_HEIGHT, 20, 0, 10, 0, 0, 0, 0};
        steps[22] = '{OP_WRITE, SEL_HEIGHT, 21, 0, 10, 0, 0, 0, 0};
        steps[23] = '{OP_WRITE, SEL_COUNT, 21, 0, 0, 0, 0, 0, 0};
        steps[24] = '{OP_QUERY, SEL_NODE, 0, 0, 0, 1, 4095, 1, INF_DIST};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (steps[i])
            send(steps[i].op, steps[i].sel, steps[i].row, steps[i].col, steps[i].val,
                 steps[i].va, steps[i].vb, steps[i].typed, steps[i].want, 1'b0);

        while (items < RANDOM_ITEMS)
        begin
            quiet = (items > QUIET_FROM);
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                a = vertex_pool[$urandom_range(0, 19)];
                b = ($urandom_range(0, 9) == 0) ? a : vertex_pool[$urandom_range(0, 19)];
                // fill whatever the query would read before asking it
                while (!query_distance(a, b, res, msel, mrow, mcol))
                    send(OP_WRITE, msel, mrow, mcol, pick_word(msel, a, b), 0, 0, 0, 0, 1'b1);
                send(OP_QUERY, SEL_NODE, 0, 0, 0, a, b, 0, 0, 1'b1);
            end
            else if (r < 90)
            begin
                sel = $urandom;
                case (sel)
                    SEL_NODE:   send(OP_WRITE, sel, vertex_pool[$urandom_range(0, 19)], $urandom,
                                     pick_word(sel, 0, 0), 0, 0, 0, 0, 1'b1);
                    SEL_SPARSE: send(OP_WRITE, sel, $urandom_range(0, 12), $urandom_range(0, 8191),
                                     pick_word(sel, 0, 0), 0, 0, 0, 0, 1'b1);
                    SEL_DIST:   send(OP_WRITE, sel, node_pool[$urandom_range(0, 11)],
                                     $urandom_range(0, 255), pick_word(sel, 0, 0), 0, 0, 0, 0, 1'b1);
                    SEL_SEP:    send(OP_WRITE, sel, node_pool[$urandom_range(0, 11)],
                                     $urandom_range(0, 63), pick_word(sel, 0, 0), 0, 0, 0, 0, 1'b1);
                    default:    send(OP_WRITE, sel, node_pool[$urandom_range(0, 11)], $urandom,
                                     pick_word(sel, 0, 0), 0, 0, 0, 0, 1'b1);
                endcase
            end
            else
            begin
                // writes that land outside their table
                case ($urandom_range(0, 2))
                    0: send(OP_WRITE, SEL_SPARSE, $urandom_range(13, 4095), $urandom, $urandom,
                            0, 0, 0, 0, 1'b0);
                    1: send(OP_WRITE, SEL_DIST, $urandom, $urandom_range(256, 8191), $urandom,
                            0, 0, 0, 0, 1'b0);
                    default: send(OP_WRITE, SEL_SEP, $urandom, $urandom_range(64, 8191), $urandom,
                                  0, 0, 0, 0, 1'b0);
                endcase
            end
        end
        s_tvalid <= 1'b0;

        while (dist_q.size() != 0)
            @(posedge clk);
        repeat (250) @(posedge clk);

        $display("covered %0d index writes and %0d distance queries, %0d results checked",
                 n_writes, n_queries, n_results);
        $display("queries took equal, ancestor and separator paths over random index contents");
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/tlq_pkg.sv
hw/rtl/tlq_ram.sv
hw/rtl/tree_label_distance_query_unit.sv
sim/testbench.sv
